// File: design/rbc_pkg.sv
// ----------------------------------------------------------------------------
// rbc_pkg: shared types and constants of the radix base converter
// Register indexes, alphabet layout, state encoding and the control and
// status bundles passed between the converter's sub-units.
// ----------------------------------------------------------------------------
package rbc_pkg;

  localparam int CHAR_W    = 8;
  localparam int RADIX_W   = 5;
  localparam int DIGIT_W   = 4;
  localparam int ALPHA_W   = 64;
  localparam int NUM_CHARS = 16;
  localparam int MAX_RADIX = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_FROM_RADIX     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FROM_ALPHA_LOW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FROM_ALPHA_HIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TO_RADIX       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TO_ALPHA_LOW    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TO_ALPHA_HIGH   = 3'd5;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_START,
    ST_DIV,
    ST_READ,
    ST_LOAD,
    ST_SEND
  } state_e;

  typedef struct packed {
    logic               start;
    logic               clear;
    logic [DIGIT_W-1:0] idx;
  } mac_ctl_t;

  typedef struct packed {
    logic go;
    logic load;
  } div_ctl_t;

  typedef struct packed {
    logic               done;
    logic               nonzero;
    logic [DIGIT_W-1:0] digit;
  } div_stat_t;

  // Fetch alphabet character idx from the low/high register pair.
  function automatic logic [CHAR_W-1:0] pick_char(input logic [ALPHA_W-1:0] low,
                                                  input logic [ALPHA_W-1:0] high,
                                                  input logic [DIGIT_W-1:0] idx);
    logic [ALPHA_W-1:0] sel;
    sel = idx[3] ? high : low;
    sel = sel >> {idx[2:0], 3'b000};
    return sel[CHAR_W-1:0];
  endfunction

endpackage

// File: design/radix_base_converter_unit.sv
// ----------------------------------------------------------------------------
// radix_base_converter_unit: streaming radix base converter
// Accumulates a number one source character per request and, on the request
// marked last, emits the value in the target radix, most significant first.
// ----------------------------------------------------------------------------
// Each input request carries one character. It is matched against the
// source alphabet (lowest matching index wins, only the first from_radix
// entries count, a radix above 16 acts as 16). A matching character is
// folded into a VALUE_BITS-bit accumulator as acc * from_radix + index,
// wrapping modulo 2^VALUE_BITS; a character outside the alphabet leaves the
// accumulator alone. The multiply-add runs bit-serially, and the block takes
// no new character until it completes; a character outside the alphabet
// starts none. On a last request the block then converts the value: a
// bit-serial restoring divider by to_radix (clamped to 2..16) produces one
// digit per division, least significant first, into a small digit RAM,
// until the quotient is zero or VALUE_BITS digits exist. The digits are
// then read back in reverse and each mapped through the target alphabet,
// one output request per digit, the final one with out_last set; the next
// digit is read only after the previous request is taken. The accumulator
// returns to zero after each number. One input request is in flight at a
// time: in_ready is high only while idle. Configuration writes are always
// taken; write them only while the block is idle. Writes to unknown
// indexes are dropped.
// ----------------------------------------------------------------------------
module radix_base_converter_unit
  import rbc_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ALPHA_W-1:0]   cfg_data_i,
  // input character channel
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [CHAR_W-1:0]    in_char_i,
  input  logic                 in_last_i,
  // output character channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [CHAR_W-1:0]    out_char_o,
  output logic                 out_last_o
);

  localparam int AW = $clog2(VALUE_BITS);

  // Configuration registers.
  logic [RADIX_W-1:0] from_radix_q;
  logic [ALPHA_W-1:0] from_alpha_low_q;
  logic [ALPHA_W-1:0] from_alpha_high_q;
  logic [RADIX_W-1:0] to_radix_q;
  logic [ALPHA_W-1:0] to_alpha_low_q;
  logic [ALPHA_W-1:0] to_alpha_high_q;

  state_e                state_q, state_d;
  logic                  in_accept;
  logic                  last_q;
  logic [AW-1:0]         dcnt_q;
  logic [CHAR_W-1:0]     out_char_q;
  logic                  out_last_q;

  logic [RADIX_W-1:0]    eff_from_radix;
  logic [RADIX_W-1:0]    eff_to_radix;
  logic                  hit;
  logic [DIGIT_W-1:0]    hit_idx;
  logic                  div_more;

  mac_ctl_t              mac_ctl;
  logic [VALUE_BITS-1:0] acc;
  logic                  mac_done;
  div_ctl_t              div_ctl;
  div_stat_t             div_stat;
  logic                  ram_re;
  logic [DIGIT_W-1:0]    ram_rdata;

  // --------------------------------------------------------------------------
  // Configuration port: always ready, unknown indexes dropped.
  // --------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      from_radix_q      <= RADIX_RESET;
      from_alpha_low_q  <= '0;
      from_alpha_high_q <= '0;
      to_radix_q        <= RADIX_RESET;
      to_alpha_low_q    <= '0;
      to_alpha_high_q   <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_FROM_RADIX:      from_radix_q      <= cfg_data_i[RADIX_W-1:0];
        CFG_FROM_ALPHA_LOW:  from_alpha_low_q  <= cfg_data_i;
        CFG_FROM_ALPHA_HIGH: from_alpha_high_q <= cfg_data_i;
        CFG_TO_RADIX:        to_radix_q        <= cfg_data_i[RADIX_W-1:0];
        CFG_TO_ALPHA_LOW:    to_alpha_low_q    <= cfg_data_i;
        CFG_TO_ALPHA_HIGH:   to_alpha_high_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp the radices to their usable ranges.
  assign eff_from_radix = (from_radix_q > RADIX_W'(MAX_RADIX)) ? RADIX_W'(MAX_RADIX)
                                                               : from_radix_q;
  always_comb begin
    if (to_radix_q < RADIX_W'(2)) begin
      eff_to_radix = RADIX_W'(2);
    end else if (to_radix_q > RADIX_W'(MAX_RADIX)) begin
      eff_to_radix = RADIX_W'(MAX_RADIX);
    end else begin
      eff_to_radix = to_radix_q;
    end
  end

  // --------------------------------------------------------------------------
  // Source alphabet lookup: scan from the top so the lowest match wins.
  // --------------------------------------------------------------------------
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int k = NUM_CHARS - 1; k >= 0; k--) begin
      if ((RADIX_W'(k) < eff_from_radix) &&
          (pick_char(from_alpha_low_q, from_alpha_high_q, DIGIT_W'(k)) == in_char_i)) begin
        hit     = 1'b1;
        hit_idx = DIGIT_W'(k);
      end
    end
  end

  assign in_accept = in_valid_i && in_ready_o;
  // Divide again while the quotient is nonzero and the digit RAM has room.
  assign div_more  = div_stat.nonzero && (dcnt_q != AW'(VALUE_BITS - 1));

  // --------------------------------------------------------------------------
  // Sequencer: next state.
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (hit) begin
            state_d = ST_MAC;
          end else if (in_last_i) begin
            state_d = ST_START;
          end
        end
      end
      ST_MAC: begin
        if (mac_done) begin
          state_d = last_q ? ST_START : ST_IDLE;
        end
      end
      ST_START: state_d = ST_DIV;
      ST_DIV: begin
        if (div_stat.done && !div_more) begin
          state_d = ST_READ;
        end
      end
      ST_READ: state_d = ST_LOAD;
      ST_LOAD: state_d = ST_SEND;
      ST_SEND: begin
        if (out_ready_i) begin
          state_d = out_last_q ? ST_IDLE : ST_READ;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: outputs.
  // --------------------------------------------------------------------------
  always_comb begin
    in_ready_o    = 1'b0;
    out_valid_o   = 1'b0;
    mac_ctl.start = 1'b0;
    mac_ctl.clear = 1'b0;
    mac_ctl.idx   = hit_idx;
    div_ctl.go    = 1'b0;
    div_ctl.load  = 1'b0;
    ram_re        = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        mac_ctl.start = in_valid_i && hit;
      end
      ST_START: begin
        // load the divider with the final value and zero the accumulator
        div_ctl.go    = 1'b1;
        div_ctl.load  = 1'b1;
        mac_ctl.clear = 1'b1;
      end
      ST_DIV: begin
        div_ctl.go = div_stat.done && div_more;
      end
      ST_READ: ram_re = 1'b1;
      ST_SEND: out_valid_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      last_q  <= 1'b0;
      dcnt_q  <= '0;
    end else begin
      state_q <= state_d;
      if (in_accept) begin
        last_q <= in_last_i;
      end
      // dcnt counts digits while dividing, then walks back down on readout
      if (state_q == ST_START) begin
        dcnt_q <= '0;
      end else if (div_ctl.go) begin
        dcnt_q <= dcnt_q + 1'b1;
      end else if ((state_q == ST_SEND) && out_ready_i && !out_last_q) begin
        dcnt_q <= dcnt_q - 1'b1;
      end
    end
  end

  // Output register: map the stored digit through the target alphabet.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_LOAD) begin
      out_char_q <= pick_char(to_alpha_low_q, to_alpha_high_q, ram_rdata);
      out_last_q <= (dcnt_q == '0);
    end
  end

  assign out_char_o = out_char_q;
  assign out_last_o = out_last_q;

  // --------------------------------------------------------------------------
  // Datapath units.
  // --------------------------------------------------------------------------
  rbc_mac #(
    .VALUE_BITS(VALUE_BITS)
  ) u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (mac_ctl),
    .radix_i (eff_from_radix),
    .acc_o   (acc),
    .done_o  (mac_done)
  );

  rbc_div #(
    .VALUE_BITS(VALUE_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (div_ctl),
    .value_i (acc),
    .radix_i (eff_to_radix),
    .stat_o  (div_stat)
  );

  rbc_ram #(
    .WIDTH(DIGIT_W),
    .DEPTH(VALUE_BITS)
  ) u_digits (
    .clk_i   (clk_i),
    .we_i    (div_stat.done),
    .waddr_i (dcnt_q),
    .wdata_i (div_stat.digit),
    .re_i    (ram_re),
    .raddr_i (dcnt_q),
    .rdata_o (ram_rdata)
  );

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input and output channels active together");

  a_mac_done_in_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_done |-> (state_q == ST_MAC))
    else $error("multiply-accumulate finished outside its state");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == ST_DIV))
    else $error("divider finished outside its state");

  a_last_at_bottom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_last_o) |-> (dcnt_q == '0))
    else $error("final output digit sent before the lowest digit");
`endif

endmodule

// File: design/rbc_ram.sv
// ----------------------------------------------------------------------------
// rbc_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rbc_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/rbc_mac.sv
// ----------------------------------------------------------------------------
// rbc_mac: bit-serial multiply-accumulate on the value register
// Computes acc * radix + idx, one accumulator bit per cycle, LSB first.
// ----------------------------------------------------------------------------
module rbc_mac
  import rbc_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mac_ctl_t              ctl_i,
  input  logic [RADIX_W-1:0]    radix_i,
  output logic [VALUE_BITS-1:0] acc_o,
  output logic                  done_o
);

  localparam int CW = $clog2(VALUE_BITS);

  logic [VALUE_BITS-1:0] acc_q, acc_d;
  logic [RADIX_W-1:0]    carry_q, carry_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic [RADIX_W:0]      sum;

  // Partial product of the current bit plus the running carry.
  always_comb begin
    sum     = {1'b0, (acc_q[0] ? radix_i : '0)} + {1'b0, carry_q};
    acc_d   = acc_q;
    carry_d = carry_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    if (ctl_i.clear) begin
      acc_d = '0;
    end else if (ctl_i.start) begin
      carry_d = {1'b0, ctl_i.idx};
      cnt_d   = CW'(VALUE_BITS - 1);
      busy_d  = 1'b1;
    end else if (busy_q) begin
      // rotate right, the new product bit enters at the top
      acc_d   = {sum[0], acc_q[VALUE_BITS-1:1]};
      carry_d = sum[RADIX_W:1];
      cnt_d   = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      carry_q <= '0;
      cnt_q   <= '0;
      busy_q  <= 1'b0;
    end else begin
      acc_q   <= acc_d;
      carry_q <= carry_d;
      cnt_q   <= cnt_d;
      busy_q  <= busy_d;
    end
  end

  assign acc_o  = acc_q;
  assign done_o = busy_q && (cnt_q == '0);

endmodule

// File: design/rbc_div.sv
// ----------------------------------------------------------------------------
// rbc_div: bit-serial restoring divider by the target radix
// Shifts the value through MSB first, one quotient bit per cycle; the
// remainder is the next output digit.
// ----------------------------------------------------------------------------
module rbc_div
  import rbc_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  div_ctl_t              ctl_i,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic [RADIX_W-1:0]    radix_i,
  output div_stat_t             stat_o
);

  localparam int CW = $clog2(VALUE_BITS);

  logic [VALUE_BITS-1:0] quo_q;
  logic [DIGIT_W-1:0]    rem_q;
  logic [CW-1:0]         cnt_q;
  logic                  busy_q;
  logic                  nz_q;
  logic                  done_q;
  logic [RADIX_W-1:0]    trial;
  logic                  ge;
  logic [RADIX_W-1:0]    diff;
  logic [DIGIT_W-1:0]    rem_step;

  always_comb begin
    trial    = {rem_q, quo_q[VALUE_BITS-1]};
    ge       = trial >= radix_i;
    diff     = trial - radix_i;
    rem_step = ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      nz_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (cnt_q == '0);
      if (ctl_i.go) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(VALUE_BITS - 1);
        rem_q  <= '0;
        nz_q   <= 1'b0;
      end else if (busy_q) begin
        rem_q <= rem_step;
        nz_q  <= nz_q | ge;
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Quotient register holds payload only; reload or shift as requested.
  always_ff @(posedge clk_i) begin
    if (ctl_i.go && ctl_i.load) begin
      quo_q <= value_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[VALUE_BITS-2:0], ge};
    end
  end

  assign stat_o.done    = done_q;
  assign stat_o.nonzero = nz_q;
  assign stat_o.digit   = rem_q;

endmodule
